// ===== sv/ifrs_pkg.sv =====
// ifrs_pkg: shared constants, payload types and fill helper for the
// interlace field row shifter. No dependencies.
package ifrs_pkg;

  localparam int MAX_SHIFT   = 63;
  localparam int MAX_WIDTH   = 4096;

  localparam int COMP_W      = 16;
  localparam int PIX_W       = 4 * COMP_W;
  localparam int WIDTH_W     = 13;
  localparam int OFFS_W      = 7;
  localparam int SHIFT_W     = $clog2(MAX_SHIFT + 1);
  localparam int STORE_DEPTH = 64;
  localparam int PTR_W       = $clog2(STORE_DEPTH);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;

  localparam logic [COMP_W-1:0] CHROMA_MID = 16'h8000;

  // pixel formats
  localparam logic FMT_RGBA = 1'b0;
  localparam logic FMT_AYUV = 1'b1;

  // register indexes (word address)
  localparam logic [1:0] REG_FIRST_OFFS  = 2'd0;
  localparam logic [1:0] REG_SECOND_OFFS = 2'd1;
  localparam logic [1:0] REG_LINE_WIDTH  = 2'd2;
  localparam logic [1:0] REG_PIX_FORMAT  = 2'd3;

  typedef struct packed {
    logic [COMP_W-1:0] comp_first;
    logic [COMP_W-1:0] comp_second;
    logic [COMP_W-1:0] comp_third;
    logic [COMP_W-1:0] comp_fourth;
    logic              frame_start;
  } item_t;

  typedef struct packed {
    logic [COMP_W-1:0] out_first;
    logic [COMP_W-1:0] out_second;
    logic [COMP_W-1:0] out_third;
    logic [COMP_W-1:0] out_fourth;
    logic              row_end;
    logic              run_last;
  } res_t;

  // one queued command: a pixel, then a run of fills
  typedef struct packed {
    logic [PIX_W-1:0]   pix;
    logic               row_end;
    logic [SHIFT_W-1:0] fills;
  } cmd_t;

  // packed pixel layout is {fourth, third, second, first}
  function automatic logic [PIX_W-1:0] fill_pix(input logic fmt);
    logic [COMP_W-1:0] chroma;
    chroma = (fmt == FMT_AYUV) ? CHROMA_MID : '0;
    return {chroma, chroma, {COMP_W{1'b0}}, {COMP_W{1'b0}}};
  endfunction

endpackage

// ===== sv/ifrs_front.sv =====
// ifrs_front: accepts pixels, tracks row and column, keeps the line store
// and turns each pixel not dropped by a left shift into a queue command. Depends on ifrs_pkg.
module ifrs_front import ifrs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  item_t              item,
  input  logic [OFFS_W-1:0]  first_offs,
  input  logic [OFFS_W-1:0]  second_offs,
  input  logic [WIDTH_W-1:0] line_width,
  input  logic               fmt,
  output logic               cmd_push,
  output cmd_t               cmd,
  input  logic               cmd_full
);

  typedef enum logic [2:0] {
    SEL_PIX   = 3'b001,
    SEL_STORE = 3'b010,
    SEL_FILL  = 3'b100
  } sel_t;

  localparam logic [WIDTH_W-1:0] MAX_WIDTH_V = WIDTH_W'(MAX_WIDTH);
  localparam logic signed [OFFS_W:0] SH_MAX = (OFFS_W+1)'(MAX_SHIFT);
  localparam logic signed [OFFS_W:0] SH_MIN = -SH_MAX;

  logic [PIX_W-1:0] store [STORE_DEPTH];
  logic [PIX_W-1:0] rd_data;

  logic [PTR_W-1:0]   ptr;
  logic [WIDTH_W-1:0] column;
  logic               odd;

  logic               stg_valid;
  sel_t               stg_sel;
  logic [PIX_W-1:0]   stg_pix;
  logic               stg_row_end;
  logic [SHIFT_W-1:0] stg_fills;

  logic                    accept;
  logic [PIX_W-1:0]        pix_in;
  logic [WIDTH_W-1:0]      col_cur;
  logic                    odd_cur;
  logic [WIDTH_W-1:0]      w_eff;
  logic                    last;
  logic [OFFS_W-1:0]       raw;
  logic signed [OFFS_W:0]  sh_raw;
  logic signed [OFFS_W:0]  sh;
  logic [OFFS_W:0]         mag_ext;
  logic [SHIFT_W-1:0]      mag;
  logic                    neg;
  logic [WIDTH_W-1:0]      mag_w;
  logic [PTR_W-1:0]        raddr;
  logic                    cls_push;
  sel_t                    cls_sel;
  logic                    cls_row_end;
  logic [SHIFT_W-1:0]      cls_fills;

  assign full   = stg_valid && cmd_full;
  assign accept = push && !full;
  assign pix_in = {item.comp_fourth, item.comp_third, item.comp_second, item.comp_first};

  assign col_cur = item.frame_start ? '0 : column;
  assign odd_cur = item.frame_start ? 1'b0 : odd;

  always_comb begin
    priority if (line_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (line_width > MAX_WIDTH_V) begin
      w_eff = MAX_WIDTH_V;
    end else begin
      w_eff = line_width;
    end
  end

  assign last = ({1'b0, col_cur} + (WIDTH_W+1)'(1)) >= {1'b0, w_eff};

  assign raw    = odd_cur ? second_offs : first_offs;
  assign sh_raw = signed'({raw[OFFS_W-1], raw});

  always_comb begin
    priority if (sh_raw > SH_MAX) begin
      sh = SH_MAX;
    end else if (sh_raw < SH_MIN) begin
      sh = SH_MIN;
    end else begin
      sh = sh_raw;
    end
  end

  assign neg     = sh[OFFS_W];
  assign mag_ext = neg ? (OFFS_W+1)'(-sh) : (OFFS_W+1)'(sh);
  assign mag     = mag_ext[SHIFT_W-1:0];
  assign mag_w   = WIDTH_W'(mag);
  assign raddr   = ptr - PTR_W'(mag);

  always_comb begin
    cls_push    = 1'b1;
    cls_sel     = SEL_PIX;
    cls_row_end = last;
    cls_fills   = '0;
    priority if (mag_w >= w_eff) begin
      cls_sel = SEL_FILL;
    end else if (!neg) begin
      priority if (col_cur < mag_w) begin
        cls_sel = SEL_FILL;
      end else if (mag == '0) begin
        cls_sel = SEL_PIX;
      end else begin
        cls_sel = SEL_STORE;
      end
    end else if (col_cur >= mag_w) begin
      // left shift: pixel itself, fills appended at row end
      cls_sel     = SEL_PIX;
      cls_row_end = 1'b0;
      cls_fills   = last ? mag : '0;
    end else begin
      cls_push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      store[ptr]  <= pix_in;
      rd_data     <= store[raddr];
      stg_sel     <= cls_sel;
      stg_pix     <= pix_in;
      stg_row_end <= cls_row_end;
      stg_fills   <= cls_fills;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      column    <= '0;
      odd       <= 1'b0;
      stg_valid <= 1'b0;
    end else begin
      if (accept) begin
        ptr       <= ptr + PTR_W'(1);
        column    <= last ? '0 : col_cur + WIDTH_W'(1);
        odd       <= last ? !odd_cur : odd_cur;
        stg_valid <= cls_push;
      end else if (stg_valid && !cmd_full) begin
        stg_valid <= 1'b0;
      end
    end
  end

  assign cmd_push = stg_valid && !cmd_full;

  always_comb begin
    cmd.row_end = stg_row_end;
    cmd.fills   = stg_fills;
    unique case (stg_sel)
      SEL_PIX:   cmd.pix = stg_pix;
      SEL_STORE: cmd.pix = rd_data;
      SEL_FILL:  cmd.pix = fill_pix(fmt);
      default:   cmd.pix = stg_pix;
    endcase
  end

endmodule

// ===== sv/ifrs_cmdq.sv =====
// ifrs_cmdq: small command queue between front and back parts.
// Depends on ifrs_pkg.
module ifrs_cmdq import ifrs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  output logic full,
  input  cmd_t wdata,
  input  logic rd,
  output logic empty,
  output cmd_t rdata
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full  = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign rdata = entries[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (rd) begin
        rptr <= rptr + QPTR_W'(1);
      end
      unique case ({wr, rd})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/ifrs_back.sv =====
// ifrs_back: expands queued commands into results, pixel first then fills,
// into an output register. Depends on ifrs_pkg.
module ifrs_back import ifrs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic fmt,
  input  logic q_empty,
  input  cmd_t head,
  output logic q_pop,
  output logic empty,
  input  logic pop,
  output res_t result
);

  typedef enum logic [1:0] {
    ST_PIX  = 2'b01,
    ST_FILL = 2'b10
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [SHIFT_W-1:0] fill_left;
  logic [SHIFT_W-1:0] fill_left_next;
  logic               out_valid;
  res_t               res_next;
  logic               load;
  logic [PIX_W-1:0]   src;
  logic               fill_end;

  assign load     = !q_empty && (!out_valid || pop);
  assign empty    = !out_valid;
  assign fill_end = fill_left == SHIFT_W'(1);

  always_comb begin
    state_next     = state;
    fill_left_next = fill_left;
    q_pop          = 1'b0;
    src            = head.pix;
    res_next       = '0;
    unique case (state)
      ST_PIX: begin
        src               = head.pix;
        res_next.row_end  = head.row_end;
        res_next.run_last = head.fills == '0;
        if (load) begin
          if (head.fills == '0) begin
            q_pop = 1'b1;
          end else begin
            state_next     = ST_FILL;
            fill_left_next = head.fills;
          end
        end
      end
      ST_FILL: begin
        src               = fill_pix(fmt);
        res_next.row_end  = fill_end;
        res_next.run_last = fill_end;
        if (load) begin
          fill_left_next = fill_left - SHIFT_W'(1);
          if (fill_end) begin
            q_pop      = 1'b1;
            state_next = ST_PIX;
          end
        end
      end
      default: begin
        state_next = ST_PIX;
      end
    endcase
    res_next.out_first  = src[COMP_W-1:0];
    res_next.out_second = src[2*COMP_W-1:COMP_W];
    res_next.out_third  = src[3*COMP_W-1:2*COMP_W];
    res_next.out_fourth = src[4*COMP_W-1:3*COMP_W];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_PIX;
      fill_left <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill_left <= fill_left_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/interlace_field_row_shifter_unit.sv =====
// interlace_field_row_shifter_unit: top level with register file, front part,
// command queue and back part. Depends on ifrs_pkg, ifrs_front, ifrs_cmdq, ifrs_back.
//
//   channel   signals                                          moves
//   input     push / full / item                               one pixel item
//   result    pop / empty / result                             one result item
//   config    psel penable pwrite paddr pwdata prdata pready   one 32-bit register word
//
// an item is accepted every cycle unless the staging register holds a command
// the queue cannot take; its command passes that register and the queue to the back
// part, whose output register takes one result per cycle while a command waits and it
// is free or popped; a left-shift row end gives its pixel plus one fill per shift; the
// four-deep queue and the staging register hold five commands before full rises
// rst is synchronous and clears tracking, queue and output state, not the line store
module interlace_field_row_shifter_unit import ifrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // input queue side
  input  logic                  push,
  output logic                  full,
  input  item_t                 item,
  // result queue side
  output logic                  empty,
  input  logic                  pop,
  output res_t                  result,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // configuration registers
  logic [OFFS_W-1:0]  first_offs;
  logic [OFFS_W-1:0]  second_offs;
  logic [WIDTH_W-1:0] line_width;
  logic               fmt;

  logic       cfg_wr;
  logic [1:0] reg_idx;

  // front to queue, queue to back
  logic cmd_push;
  cmd_t cmd;
  logic cmd_full;
  logic q_empty;
  logic q_pop;
  cmd_t head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      first_offs  <= '0;
      second_offs <= '0;
      line_width  <= WIDTH_W'(1920);
      fmt         <= FMT_RGBA;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FIRST_OFFS:  first_offs  <= pwdata[OFFS_W-1:0];
        REG_SECOND_OFFS: second_offs <= pwdata[OFFS_W-1:0];
        REG_LINE_WIDTH:  line_width  <= pwdata[WIDTH_W-1:0];
        REG_PIX_FORMAT:  fmt         <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register reads, raw stored bits zero extended
  always_comb begin
    unique case (reg_idx)
      REG_FIRST_OFFS:  prdata = APB_DATA_W'(first_offs);
      REG_SECOND_OFFS: prdata = APB_DATA_W'(second_offs);
      REG_LINE_WIDTH:  prdata = APB_DATA_W'(line_width);
      REG_PIX_FORMAT:  prdata = APB_DATA_W'(fmt);
      default:         prdata = '0;
    endcase
  end

  // front: row/column tracking, line store, classification
  ifrs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .item        (item),
    .first_offs  (first_offs),
    .second_offs (second_offs),
    .line_width  (line_width),
    .fmt         (fmt),
    .cmd_push    (cmd_push),
    .cmd         (cmd),
    .cmd_full    (cmd_full)
  );

  // decoupling queue
  ifrs_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_push),
    .full  (cmd_full),
    .wdata (cmd),
    .rd    (q_pop),
    .empty (q_empty),
    .rdata (head)
  );

  // back: pixel then fill run, registered output
  ifrs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .fmt     (fmt),
    .q_empty (q_empty),
    .head    (head),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ===== sv/ifrs_checker.sv =====
// ifrs_checker: port-level assertions for the row shifter, bound to the top.
// Depends on ifrs_pkg and interlace_field_row_shifter_unit.
module ifrs_checker import ifrs_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  push,
  input logic  full,
  input item_t item,
  input logic  empty,
  input logic  pop,
  input res_t  result
);

  // reset leaves nothing waiting and room for input
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not clear after reset");

  // a waiting result that is not taken holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result changed while stalled");

  // a row always ends on the last result of its item
  a_row_end_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.row_end) |-> result.run_last)
    else $error("row end not on last result of item");

  // input backs up only while results are waiting
  a_full_has_out: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("input full with no result waiting");

endmodule

bind interlace_field_row_shifter_unit ifrs_checker u_ifrs_checker (.*);

// ===== verif/interlace_field_row_shifter_unit_tb.sv =====
// interlace_field_row_shifter_unit_tb: self-checking bench for the row shifter,
// with directed and random pixel rows, register writes over apb and a checker
// that predicts every result. Depends on ifrs_pkg and interlace_field_row_shifter_unit.
module interlace_field_row_shifter_unit_tb;
  import ifrs_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 24;   // covers front, queue and a drop-only item
  localparam int ITEM_TARGET   = 235;  // directed part plus random pixels, at least this many in all
  localparam int HOLD_AT       = 40;   // accepted items before the long pop hold-off
  localparam int HOLD_CYCLES   = 300;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  item_t                 item = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  res_t                  result;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  interlace_field_row_shifter_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .empty   (empty),
    .pop     (pop),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // pixels waiting to be offered, and shifted pixels the block owes us
  item_t pend_pixels[$];
  res_t  shifted_expect[$];

  int n_queued    = 0;
  int n_accepted  = 0;
  int n_results   = 0;
  int mismatch_cnt = 0;
  int cycle_cnt   = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  bit pix_taken   = 1'b0;

  // shadow of the register file, updated as each write completes
  logic [OFFS_W-1:0]  cfg_first  = '0;
  logic [OFFS_W-1:0]  cfg_second = '0;
  logic [WIDTH_W-1:0] cfg_width  = 13'd1920;
  logic               cfg_format = FMT_RGBA;

  // shadow of the row tracking and the line store
  logic [PIX_W-1:0] line_mem [STORE_DEPTH];
  logic [PTR_W-1:0] wr_ptr  = '0;
  int unsigned      col_pos = 0;
  logic             odd_row = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // 7-bit two's complement offset, clamped to the largest supported shift
  function automatic int field_shift(input logic [OFFS_W-1:0] raw);
    int v;
    v = int'(signed'(raw));
    if (v > MAX_SHIFT) v = MAX_SHIFT;
    if (v < -MAX_SHIFT) v = -MAX_SHIFT;
    return v;
  endfunction

  function automatic void owe_pixel(input logic [PIX_W-1:0] pv, input logic rend,
                                    input logic rlast);
    res_t r;
    r.out_first  = pv[15:0];
    r.out_second = pv[31:16];
    r.out_third  = pv[47:32];
    r.out_fourth = pv[63:48];
    r.row_end    = rend;
    r.run_last   = rlast;
    shifted_expect.push_back(r);
  endfunction

  // work out what one accepted pixel makes the block emit
  function automatic void predict_row_shift(input item_t px);
    logic [PIX_W-1:0] pv;
    logic [PIX_W-1:0] fill;
    logic [PTR_W-1:0] rd_ptr;
    int unsigned      w;
    int unsigned      c;
    int unsigned      mag;
    int               sh;
    logic             last;
    pv = {px.comp_fourth, px.comp_third, px.comp_second, px.comp_first};
    w = cfg_width;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (px.frame_start) begin
      col_pos = 0;
      odd_row = 1'b0;
    end
    c = col_pos;
    last = (c + 1 >= w);
    sh = field_shift(odd_row ? cfg_second : cfg_first);
    mag = (sh < 0) ? -sh : sh;
    // ayuv fill is black with mid-scale chroma
    fill = (cfg_format == FMT_AYUV) ? {CHROMA_MID, CHROMA_MID, 32'h0} : '0;
    line_mem[wr_ptr] = pv;
    if (mag >= w) begin
      // shift swallows the whole row: one fill per pixel
      owe_pixel(fill, last, 1'b1);
    end else if (sh >= 0) begin
      // right shift: fills on the leading columns, then delayed pixels
      rd_ptr = wr_ptr - PTR_W'(mag);
      owe_pixel((c < mag) ? fill : line_mem[rd_ptr], last, 1'b1);
    end else if (c >= mag) begin
      // left shift: leading columns dropped, fills trail the row's last pixel
      owe_pixel(pv, last && mag == 0, !(last && mag > 0));
      if (last)
        for (int k = 0; k < mag; k++) owe_pixel(fill, k + 1 == mag, k + 1 == mag);
    end
    wr_ptr = wr_ptr + PTR_W'(1);
    if (last) begin
      col_pos = 0;
      odd_row = ~odd_row;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // input side: accept at the rising edge, change push/item at the falling edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pix_taken = 1'b0;
    if (!rst && push && !full) begin
      predict_row_shift(item);
      pix_taken = 1'b1;
      n_accepted++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || pix_taken) begin
      // random gaps, except for a stretch where the sender runs flat out
      if (pend_pixels.size() != 0 &&
          !((n_accepted < 100 || n_accepted >= 180) && $urandom_range(99) < 7)) begin
        item <= pend_pixels.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: pop at random, plus one long hold-off so the block backs up
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      pop <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      pop <= !((n_results < 150 || n_results >= 260) && $urandom_range(99) < 7);
    end
  end

  // compare each popped item against the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (!rst && pop && !empty) begin
      if (shifted_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d: %p", n_results, result));
      end else begin
        want = shifted_expect.pop_front();
        if (result.out_first !== want.out_first)
          report_mismatch($sformatf("result %0d out_first %h want %h",
                                    n_results, result.out_first, want.out_first));
        if (result.out_second !== want.out_second)
          report_mismatch($sformatf("result %0d out_second %h want %h",
                                    n_results, result.out_second, want.out_second));
        if (result.out_third !== want.out_third)
          report_mismatch($sformatf("result %0d out_third %h want %h",
                                    n_results, result.out_third, want.out_third));
        if (result.out_fourth !== want.out_fourth)
          report_mismatch($sformatf("result %0d out_fourth %h want %h",
                                    n_results, result.out_fourth, want.out_fourth));
        if (result.row_end !== want.row_end)
          report_mismatch($sformatf("result %0d row_end %b want %b",
                                    n_results, result.row_end, want.row_end));
        if (result.run_last !== want.run_last)
          report_mismatch($sformatf("result %0d run_last %b want %b",
                                    n_results, result.run_last, want.run_last));
      end
      n_results++;
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("interlace_field_row_shifter_unit verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // apb write: setup cycle, then access cycle; register lands at the access edge
  task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FIRST_OFFS:  cfg_first  = val[OFFS_W-1:0];
      REG_SECOND_OFFS: cfg_second = val[OFFS_W-1:0];
      REG_LINE_WIDTH:  cfg_width  = val[WIDTH_W-1:0];
      REG_PIX_FORMAT:  cfg_format = val[0];
      default: ;
    endcase
  endtask

  task automatic program_shifter(input logic [OFFS_W-1:0] first_offs,
                                 input logic [OFFS_W-1:0] second_offs,
                                 input logic [WIDTH_W-1:0] width,
                                 input logic fmt);
    write_reg(REG_FIRST_OFFS, APB_DATA_W'(first_offs));
    write_reg(REG_SECOND_OFFS, APB_DATA_W'(second_offs));
    write_reg(REG_LINE_WIDTH, APB_DATA_W'(width));
    write_reg(REG_PIX_FORMAT, APB_DATA_W'(fmt));
  endtask

  function automatic logic [COMP_W-1:0] rand_comp();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return COMP_W'($urandom);
    endcase
  endfunction

  // rows of random pixels; noise is the percentage of stray frame starts
  task automatic queue_pixels(input int n, input bit fresh_frame, input int noise);
    item_t px;
    for (int i = 0; i < n; i++) begin
      px.comp_first  = rand_comp();
      px.comp_second = rand_comp();
      px.comp_third  = rand_comp();
      px.comp_fourth = rand_comp();
      px.frame_start = (i == 0 && fresh_frame) || ($urandom_range(99) < noise);
      pend_pixels.push_back(px);
      n_queued++;
    end
  endtask

  // offsets around the row width, with the saturation and sign extremes mixed in
  function automatic logic [OFFS_W-1:0] pick_offset(input int w);
    int m;
    case ($urandom_range(5))
      0: return 7'h00;
      1: return 7'h40;
      2: return 7'h3F;
      3: return OFFS_W'($urandom);
      default: begin
        m = $urandom_range((w + 1 > MAX_SHIFT) ? MAX_SHIFT : w + 1);
        return $urandom_range(1) ? OFFS_W'(m) : OFFS_W'(-m);
      end
    endcase
  endfunction

  // everything offered, everything owed has arrived, then let drop-only items drain
  task automatic wait_idle();
    while (pend_pixels.size() != 0 || push || shifted_expect.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int w;
    int n;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings, no shift: extreme component values pass straight through
    program_shifter(7'h00, 7'h00, 13'd1920, FMT_RGBA);
    pend_pixels.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1});
    pend_pixels.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0});
    wait_idle();

    // zero width acts as one: every shift covers the row, ayuv fill
    program_shifter(7'h01, 7'h7F, 13'd0, FMT_AYUV);
    queue_pixels(3, 1'b1, 0);
    wait_idle();

    // short rows, right shift on even rows, left shift with trailing fills on odd
    program_shifter(7'h02, 7'h7E, 13'd4, FMT_RGBA);
    queue_pixels(8, 1'b1, 0);
    wait_idle();

    // -64 saturates to -63, both offsets beyond the width
    program_shifter(7'h40, 7'h3F, 13'd3, FMT_AYUV);
    queue_pixels(6, 1'b1, 0);
    wait_idle();

    // oversized width clamps, row left open; then the width shrinks under it
    program_shifter(7'h00, 7'h00, 13'd8191, FMT_RGBA);
    queue_pixels(3, 1'b1, 0);
    wait_idle();
    program_shifter(7'h01, 7'h01, 13'd2, FMT_AYUV);
    queue_pixels(2, 1'b0, 0);
    wait_idle();

    // long steady phase; the pop hold-off lands in here and backs the block up
    program_shifter(7'h7E, 7'h03, 13'd5, FMT_RGBA);
    queue_pixels(40, 1'b1, 0);
    wait_idle();

    // widest fill burst: left shift by 63 on a 64-pixel row
    program_shifter(7'h40, 7'h00, 13'd64, FMT_AYUV);
    queue_pixels(64, 1'b1, 0);
    wait_idle();

    // deepest line store reach: right shift by 63
    program_shifter(7'h3F, 7'h41, 13'd64, FMT_RGBA);
    queue_pixels(64, 1'b1, 0);
    wait_idle();

    // random phases: mostly whole rows of short width, some stray frame starts,
    // sometimes continuing a row left open by the phase before
    while (n_queued < ITEM_TARGET) begin
      if ($urandom_range(11) == 0) begin
        w = MAX_WIDTH;
        n = $urandom_range(6, 2);
      end else begin
        w = ($urandom_range(3) == 0) ? $urandom_range(40, 13) : $urandom_range(8, 1);
        n = w * $urandom_range(3, 1);
        if (n > 48) n = 48;
      end
      program_shifter(pick_offset(w), pick_offset(w), WIDTH_W'(w), 1'($urandom_range(1)));
      queue_pixels(n, 1'($urandom_range(1)), 4);
      wait_idle();
    end

    if (shifted_expect.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", shifted_expect.size()));
    if (mismatch_cnt == 0) begin
      $display("interlace_field_row_shifter_unit verification clean");
    end else begin
      $display("interlace_field_row_shifter_unit verification failed");
    end
    $finish;
  end

endmodule
